/* design/lock_to_key_encoder_macros.svh */
// ----------------------------------------------------------------------------
// lock_to_key_encoder assertion macros
// Concurrent assertion shorthands clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef LOCK_TO_KEY_ENCODER_MACROS_SVH
`define LOCK_TO_KEY_ENCODER_MACROS_SVH

// same-cycle implication
`define LTK_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lock_to_key_encoder: same-cycle check failed");

// next-cycle implication
`define LTK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lock_to_key_encoder: next-cycle check failed");

`endif

/* design/ltk_pkg.sv */
// ----------------------------------------------------------------------------
// ltk_pkg
// Shared types, constants and character tables of the lock to key encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ltk_pkg;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [3:0] ESC_LAST   = 4'd9;

	typedef struct packed {
		logic [7:0] kb;
		logic       esc;
		logic       head;
		logic       err;
	} ltk_job_t;

	function automatic logic [7:0] ltk_swap(input logic [7:0] v);
		return {v[3:0], v[7:4]};
	endfunction

	function automatic logic ltk_is_escaped(input logic [7:0] kb);
		logic r;
		unique case (kb)
			8'd0, 8'd5, 8'd36, 8'd96, 8'd124, 8'd126: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// three decimal digits of an escaped key byte, as ASCII
	function automatic logic [23:0] ltk_digits(input logic [7:0] kb);
		logic [23:0] r;
		unique case (kb)
			8'd5:    r = "005";
			8'd36:   r = "036";
			8'd96:   r = "096";
			8'd124:  r = "124";
			8'd126:  r = "126";
			default: r = "000";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ltk_esc_char(input logic [7:0] kb, input logic [3:0] idx);
		logic [23:0] d;
		logic [7:0]  r;
		d = ltk_digits(kb);
		unique case (idx)
			4'd0:    r = "/";
			4'd1:    r = "%";
			4'd2:    r = "D";
			4'd3:    r = "C";
			4'd4:    r = "N";
			4'd5:    r = d[23:16];
			4'd6:    r = d[15:8];
			4'd7:    r = d[7:0];
			4'd8:    r = "%";
			4'd9:    r = "/";
			default: r = CHAR_NUL;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/ltk_front.sv */
// ----------------------------------------------------------------------------
// ltk_front
// Accepts message bytes, tracks the lock and classifies each lock byte into at most one job.
// ----------------------------------------------------------------------------
`default_nettype none

module ltk_front import ltk_pkg::*; #(
	parameter int PREFIX_SKIP = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  msg_byte,
	input  wire logic        msg_end,
	input  wire logic [15:0] local_port,
	output logic             job_valid,
	output ltk_job_t         job
);

	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_LOCK = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	logic [2:0] skip_count_q;
	logic [1:0] phase_q;
	logic [1:0] lock_length_q;
	logic [7:0] first_lock_q;
	logic [7:0] prev_lock_q;
	logic [7:0] last_raw_q;

	logic [7:0] magic;
	logic [7:0] raw;
	logic       skipping;
	logic       in_lock;

	assign magic    = local_port[7:0] + local_port[15:8];
	assign raw      = msg_byte ^ prev_lock_q;
	assign skipping = (phase_q == PH_SKIP) && (skip_count_q < 3'(PREFIX_SKIP));
	assign in_lock  = ((phase_q == PH_SKIP) || (phase_q == PH_LOCK)) && !skipping;

	always_comb begin
		job_valid = 1'b0;
		job       = '0;
		if (accept) begin
			if (msg_end) begin
				if ((phase_q == PH_SKIP) || (phase_q == PH_LOCK)) begin
					job_valid = 1'b1;
					job.err   = 1'b1;
				end
			end else if (in_lock) begin
				if (msg_byte == CHAR_NUL) begin
					job_valid = 1'b1;
					job.err   = 1'b1;
				end else if (msg_byte == CHAR_SPACE) begin
					job_valid = 1'b1;
					if (lock_length_q < 2'd2) begin
						job.err = 1'b1;
					end else begin
						job.kb   = ltk_swap(first_lock_q ^ last_raw_q ^ magic);
						job.head = 1'b1;
						job.esc  = ltk_is_escaped(job.kb);
					end
				end else if (lock_length_q != 2'd0) begin
					job_valid = 1'b1;
					job.kb    = ltk_swap(raw);
					job.esc   = ltk_is_escaped(job.kb);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q  <= '0;
			phase_q       <= PH_SKIP;
			lock_length_q <= '0;
			first_lock_q  <= '0;
			prev_lock_q   <= '0;
			last_raw_q    <= '0;
		end else if (accept) begin
			if (msg_end) begin
				skip_count_q  <= '0;
				phase_q       <= PH_SKIP;
				lock_length_q <= '0;
				first_lock_q  <= '0;
				prev_lock_q   <= '0;
				last_raw_q    <= '0;
			end else if (skipping) begin
				skip_count_q <= skip_count_q + 3'd1;
			end else if (in_lock) begin
				phase_q <= PH_LOCK;
				if ((msg_byte == CHAR_NUL) || (msg_byte == CHAR_SPACE)) begin
					phase_q <= PH_DONE;
				end else if (lock_length_q == 2'd0) begin
					first_lock_q  <= msg_byte;
					prev_lock_q   <= msg_byte;
					lock_length_q <= 2'd1;
				end else begin
					last_raw_q    <= raw;
					prev_lock_q   <= msg_byte;
					lock_length_q <= 2'd2;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* design/ltk_job_fifo.sv */
// ----------------------------------------------------------------------------
// ltk_job_fifo
// Short job queue between the front classifier and the back expander.
// ----------------------------------------------------------------------------
`default_nettype none

module ltk_job_fifo import ltk_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire ltk_job_t  wr_data,
	input  wire logic      rd_en,
	output ltk_job_t       rd_data,
	output logic           full,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ltk_job_t        mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* design/ltk_back.sv */
// ----------------------------------------------------------------------------
// ltk_back
// Expands queued jobs into key characters and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltk_back import ltk_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ltk_job_t    job,
	input  wire logic        job_empty,
	output logic             job_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [7:0]       out_char,
	output logic             head_part,
	output logic             key_done,
	output logic             lock_error
);

	logic       valid_q;
	logic [3:0] idx_q;
	logic       advance;
	logic       load;
	logic       last;
	logic [7:0] nxt_char;
	logic       nxt_done;

	assign advance = !valid_q || pop;
	assign load    = advance && !job_empty;
	assign last    = !job.esc || job.err || (idx_q == ESC_LAST);
	assign job_pop = load && last;
	assign empty   = !valid_q;

	always_comb begin
		if (job.err) begin
			nxt_char = CHAR_NUL;
			nxt_done = 1'b1;
		end else if (job.esc) begin
			nxt_char = ltk_esc_char(job.kb, idx_q);
			nxt_done = job.head && (idx_q == ESC_LAST);
		end else begin
			nxt_char = job.kb;
			nxt_done = job.head;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char   <= nxt_char;
			head_part  <= job.head && !job.err;
			key_done   <= nxt_done;
			lock_error <= job.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= load;
			if (load) begin
				idx_q <= last ? '0 : idx_q + 4'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/lock_to_key_encoder.sv */
// ----------------------------------------------------------------------------
// lock_to_key_encoder
// Turns the lock of a handshake message into escaped key text.
// ----------------------------------------------------------------------------
// Message bytes enter one per cycle whenever full is low. The front end
// classifies each byte and posts at most one job into a JOB_DEPTH-entry
// queue; the back end drains it one character per cycle through its output
// register while pop is high. A plain key byte gives one output character,
// an escaped key byte ten (/%DCNnnn%/), so input throughput is one byte per
// cycle except while the job queue is full, as when escapes or a low pop
// back it up. The head key byte comes after the body bytes, flagged by
// head_part; key_done marks its last character or an error transaction (lock_error, out_char zero).
`default_nettype none

`include "lock_to_key_encoder_macros.svh"

module lock_to_key_encoder import ltk_pkg::*; #(
	parameter int PREFIX_SKIP = 6,
	parameter int JOB_DEPTH   = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        local_port_we,
	input  wire logic [15:0] local_port,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  msg_byte,
	input  wire logic        msg_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_char,
	output logic             head_part,
	output logic             key_done,
	output logic             lock_error
);

	logic [15:0] local_port_q;
	logic        accept;
	logic        job_valid;
	ltk_job_t    job_in;
	ltk_job_t    job_out;
	logic        job_empty;
	logic        job_pop;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= '0;
		end else if (local_port_we) begin
			local_port_q <= local_port;
		end
	end

	ltk_front #(.PREFIX_SKIP(PREFIX_SKIP)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.msg_byte  (msg_byte),
		.msg_end   (msg_end),
		.local_port(local_port_q),
		.job_valid (job_valid),
		.job       (job_in)
	);

	ltk_job_fifo #(.DEPTH(JOB_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_valid),
		.wr_data(job_in),
		.rd_en  (job_pop),
		.rd_data(job_out),
		.full   (full),
		.empty  (job_empty)
	);

	ltk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.head_part (head_part),
		.key_done  (key_done),
		.lock_error(lock_error)
	);

	`LTK_ASSERT_NOW(a_job_room, job_valid, accept)
	`LTK_ASSERT_NOW(a_err_shape, !empty && lock_error, out_char == CHAR_NUL && key_done && !head_part)
	`LTK_ASSERT_NOW(a_done_head, !empty && key_done && !lock_error, head_part)
	`LTK_ASSERT_NEXT(a_pop_moves, job_pop, !empty)

endmodule

`default_nettype wire
